>>> src/rlcf_pkg.sv
`timescale 1ns / 1ps
package rlcf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CP_RD,
    ST_CP_WR,
    ST_SP_RD,
    ST_SP_EV,
    ST_MV_RD,
    ST_MV_WR,
    ST_RD_CMD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_BURST = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [1:0] REG_BURST_LIMIT = 2'd0;
  localparam logic [1:0] REG_MIN_CHARS   = 2'd1;

  localparam logic [3:0] BURST_LIMIT_RST = 4'd5;
  localparam logic [7:0] MIN_CHARS_RST   = 8'd2;

  localparam int unsigned FLUSH_RUN = 32;

  localparam logic [7:0] CHAR_LF       = 8'h0a;
  localparam logic [7:0] CHAR_CR       = 8'h0d;
  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam logic [7:0] PRINTABLE_LO  = 8'd32;
  localparam logic [7:0] PRINTABLE_END = 8'd127;

endpackage

>>> src/radio_line_command_framer.sv
`timescale 1ns / 1ps
// radio line command framer
// input channel (in_valid_i / in_stall_o) carries one item: cmd_i and data_byte_i.
//   payload byte: the byte that completes a non-zero packet within the burst limit
//   then copies it into the line store, through ST_CP_RD and ST_CP_WR per byte.
//   end of burst: walks the line store through one shared read port (ST_SP_RD,
//   ST_SP_EV per byte), printable bytes go to the command store as they pass,
//   then moves a leftover partial line to the front (ST_MV_RD, ST_MV_WR per
//   byte); it goes straight to its result when nothing was received.
//   read: gives one character from the registered read of the command store.
// the block takes one item at a time; in_stall_o is high while it works.
// output channel (out_valid_o / out_stall_i) gives one result for end of burst
//   and for read, none for payload bytes; the result sits in an output register,
//   so payload bytes are still taken while the receiver stalls, and a new
//   result-bearing item waits at its last step until the register frees.
// config port (cfg_valid_i / cfg_ready_o) writes burst_packet_limit (index 0)
//   and min_command_chars (index 1); other indexes are ignored.
// reset clears counters, queue pointers and restores register defaults; the
//   stores need no clearing.
module radio_line_command_framer
  import rlcf_pkg::*;
#(
  parameter int unsigned LINE_DEPTH   = 256,
  parameter int unsigned QUEUE_SLOTS  = 16,
  parameter int unsigned PACKET_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       got_data_o,
  output logic       queue_empty_o,
  output logic [7:0] char_out_o,
  output logic       last_of_command_o,
  output logic [4:0] pending_commands_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned LAW = $clog2(LINE_DEPTH);
  localparam int unsigned QW  = $clog2(QUEUE_SLOTS);
  localparam int unsigned CW  = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned FW  = $clog2(PACKET_BYTES + 1);
  localparam int unsigned PIW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int unsigned NCW = (LAW > 8) ? LAW + 1 : 9;
  localparam int unsigned CMD_DEPTH = (1 << QW) * LINE_DEPTH;
  localparam logic [LAW-1:0] LINE_MAX = LAW'(LINE_DEPTH - 1);

  state_e state_q, state_d;

  logic [3:0] limit_q;
  logic [7:0] min_chars_q;

  logic [FW-1:0]  fill_q;
  logic           nonzero_q;
  logic [3:0]     burst_pk_q;
  logic           burst_got_q;
  logic [LAW-1:0] line_len_q;
  logic [QW-1:0]  head_q, tail_q;
  logic [CW-1:0]  count_q;
  logic [LAW-1:0] roff_q;

  logic [FW-1:0]  cp_k_q, cp_n_q;
  logic [LAW-1:0] p_q, seg_q, sn_q, mv_k_q;

  logic           res_got_q, res_empty_q, res_last_q;
  logic [7:0]     res_char_q;

  logic           out_valid_q, out_got_q, out_empty_q, out_last_q;
  logic [7:0]     out_char_q;
  logic [4:0]     out_pend_q;

  logic [LAW-1:0] cmd_len_q [QUEUE_SLOTS];

  // memories
  logic [7:0] pk_mem   [PACKET_BYTES];
  logic [7:0] line_mem [LINE_DEPTH];
  logic [7:0] cmd_mem  [CMD_DEPTH];
  logic [7:0] pk_rdata, line_rdata, cmd_rdata;

  logic           pk_we;
  logic [PIW-1:0] pk_waddr, pk_raddr;
  logic           ls_we;
  logic [LAW-1:0] ls_waddr, ls_raddr;
  logic [7:0]     ls_wdata;
  logic           cs_we;
  logic [QW+LAW-1:0] cs_waddr, cs_raddr;

  logic in_acc, slot_free;
  cmd_e in_cmd;

  // split step decode
  logic           is_term, is_nul, is_print, q_has_room, commit_ok, at_end, flush;
  logic [LAW-1:0] sn_inc, seg_next, p_next, rem;
  logic [7:0]     need;

  always_comb begin
    pk_waddr = fill_q[PIW-1:0];
    pk_raddr = cp_k_q[PIW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (pk_we) begin
      pk_mem[pk_waddr] <= data_byte_i;
    end
    pk_rdata <= pk_mem[pk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      line_mem[ls_waddr] <= ls_wdata;
    end
    line_rdata <= line_mem[ls_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) begin
      cmd_mem[cs_waddr] <= line_rdata;
    end
    cmd_rdata <= cmd_mem[cs_raddr];
  end

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_cmd      = cmd_e'(cmd_i);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    need       = (min_chars_q == 8'd0) ? 8'd1 : min_chars_q;
    is_term    = (line_rdata == CHAR_LF) || (line_rdata == CHAR_CR);
    is_nul     = (line_rdata == CHAR_NUL);
    is_print   = (line_rdata >= PRINTABLE_LO) && (line_rdata < PRINTABLE_END);
    q_has_room = (count_q < CW'(QUEUE_SLOTS));
    sn_inc     = is_print ? sn_q + 1'b1 : sn_q;
    p_next     = p_q + 1'b1;
    seg_next   = is_term ? p_next : seg_q;
    at_end     = (p_next == line_len_q);
    rem        = line_len_q - seg_next;
    flush      = at_end && !is_term && !is_nul && (32'(rem) >= FLUSH_RUN);
    commit_ok  = q_has_room && (NCW'(sn_inc) >= NCW'(need));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_BYTE: begin
              if ((burst_pk_q < limit_q) && (fill_q + 1'b1 == FW'(PACKET_BYTES))
                  && (nonzero_q || (data_byte_i != 8'd0))) begin
                state_d = ST_CP_RD;
              end
            end
            CMD_BURST: state_d = (burst_got_q && line_len_q != '0) ? ST_SP_RD : ST_DONE;
            CMD_READ:  state_d = (count_q == '0) ? ST_DONE : ST_RD_CMD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_CP_RD: state_d = ST_CP_WR;
      ST_CP_WR: state_d = (cp_k_q + 1'b1 == cp_n_q) ? ST_IDLE : ST_CP_RD;
      ST_SP_RD: state_d = ST_SP_EV;
      ST_SP_EV: begin
        if (is_nul || flush || (at_end && rem == '0)) begin
          state_d = ST_DONE;
        end else if (at_end) begin
          state_d = (seg_next != '0) ? ST_MV_RD : ST_DONE;
        end else begin
          state_d = ST_SP_RD;
        end
      end
      ST_MV_RD:  state_d = ST_MV_WR;
      ST_MV_WR:  state_d = (mv_k_q + 1'b1 == line_len_q) ? ST_DONE : ST_MV_RD;
      ST_RD_CMD: state_d = ST_DONE;
      ST_DONE:   state_d = slot_free ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    pk_we      = 1'b0;
    ls_we      = 1'b0;
    ls_waddr   = line_len_q;
    ls_wdata   = pk_rdata;
    ls_raddr   = p_q;
    cs_we      = 1'b0;
    cs_waddr   = {tail_q, sn_q};
    cs_raddr   = {head_q, roff_q};
    unique case (state_q)
      ST_IDLE: begin
        pk_we = in_acc && (in_cmd == CMD_BYTE) && (burst_pk_q < limit_q);
      end
      ST_CP_WR: ls_we = 1'b1;
      ST_SP_EV: cs_we = is_print && q_has_room;
      ST_MV_RD: ls_raddr = seg_q + mv_k_q;
      ST_MV_WR: begin
        ls_we    = 1'b1;
        ls_waddr = mv_k_q;
        ls_wdata = line_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= BURST_LIMIT_RST;
      min_chars_q <= MIN_CHARS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BURST_LIMIT: limit_q     <= cfg_data_i[3:0];
        REG_MIN_CHARS:   min_chars_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SP_EV && commit_ok && (is_term || is_nul || flush)) begin
      cmd_len_q[tail_q] <= sn_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      nonzero_q   <= 1'b0;
      burst_pk_q  <= '0;
      burst_got_q <= 1'b0;
      line_len_q  <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      roff_q      <= '0;
      cp_k_q      <= '0;
      cp_n_q      <= '0;
      p_q         <= '0;
      seg_q       <= '0;
      sn_q        <= '0;
      mv_k_q      <= '0;
      res_got_q   <= 1'b0;
      res_empty_q <= 1'b0;
      res_last_q  <= 1'b0;
      res_char_q  <= '0;
      out_valid_q <= 1'b0;
      out_got_q   <= 1'b0;
      out_empty_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_char_q  <= '0;
      out_pend_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_cmd)
              CMD_BYTE: begin
                if (burst_pk_q < limit_q) begin
                  if (fill_q + 1'b1 == FW'(PACKET_BYTES)) begin
                    fill_q     <= '0;
                    nonzero_q  <= 1'b0;
                    burst_pk_q <= burst_pk_q + 1'b1;
                    if (nonzero_q || (data_byte_i != 8'd0)) begin
                      burst_got_q <= 1'b1;
                      cp_k_q      <= '0;
                      // a full store is cleared before the packet goes in
                      if (line_len_q == LINE_MAX) begin
                        line_len_q <= '0;
                        cp_n_q     <= FW'((LINE_DEPTH - 1 < PACKET_BYTES) ?
                                          LINE_DEPTH - 1 : PACKET_BYTES);
                      end else if (32'(LINE_MAX - line_len_q) < PACKET_BYTES) begin
                        cp_n_q <= FW'(LINE_MAX - line_len_q);
                      end else begin
                        cp_n_q <= FW'(PACKET_BYTES);
                      end
                    end
                  end else begin
                    fill_q    <= fill_q + 1'b1;
                    nonzero_q <= nonzero_q || (data_byte_i != 8'd0);
                  end
                end
              end
              CMD_BURST: begin
                res_got_q   <= burst_got_q;
                res_empty_q <= 1'b0;
                res_last_q  <= 1'b0;
                res_char_q  <= '0;
                fill_q      <= '0;
                nonzero_q   <= 1'b0;
                burst_pk_q  <= '0;
                burst_got_q <= 1'b0;
                p_q         <= '0;
                seg_q       <= '0;
                sn_q        <= '0;
              end
              CMD_READ: begin
                res_got_q   <= 1'b0;
                res_empty_q <= (count_q == '0);
                res_last_q  <= 1'b0;
                res_char_q  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_CP_WR: begin
          line_len_q <= line_len_q + 1'b1;
          cp_k_q     <= cp_k_q + 1'b1;
        end
        ST_SP_EV: begin
          p_q   <= p_next;
          sn_q  <= (is_term || is_nul) ? '0 : sn_inc;
          seg_q <= seg_next;
          mv_k_q <= '0;
          if (commit_ok && (is_term || is_nul || flush)) begin
            tail_q  <= (tail_q == QW'(QUEUE_SLOTS - 1)) ? '0 : tail_q + 1'b1;
            count_q <= count_q + 1'b1;
          end
          if (is_nul || flush) begin
            line_len_q <= '0;
          end else if (at_end) begin
            line_len_q <= rem;
          end
        end
        ST_MV_WR: mv_k_q <= mv_k_q + 1'b1;
        ST_RD_CMD: begin
          res_char_q <= cmd_rdata;
          if (roff_q + 1'b1 >= cmd_len_q[head_q]) begin
            res_last_q <= 1'b1;
            roff_q     <= '0;
            head_q     <= (head_q == QW'(QUEUE_SLOTS - 1)) ? '0 : head_q + 1'b1;
            count_q    <= count_q - 1'b1;
          end else begin
            roff_q <= roff_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_got_q   <= res_got_q;
            out_empty_q <= res_empty_q;
            out_last_q  <= res_last_q;
            out_char_q  <= res_char_q;
            out_pend_q  <= 5'(count_q);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign got_data_o         = out_got_q;
  assign queue_empty_o      = out_empty_q;
  assign char_out_o         = out_char_q;
  assign last_of_command_o  = out_last_q;
  assign pending_commands_o = out_pend_q;

endmodule
